@@ rtl/core/klt_pkg.sv @@
// Shared types, codes and helpers for the key lifetime table.
package klt_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int ID_W        = 32;
    localparam int TIME_W      = 64;
    localparam int REQ_W       = 3;
    localparam int STATUS_W    = 2;
    localparam int COUNT_W     = 5;

    typedef enum logic [REQ_W-1:0] {
        REQ_WRITE       = 3'd0,
        REQ_DELETE      = 3'd1,
        REQ_FIND_SEND   = 3'd2,
        REQ_FIND_ACCEPT = 3'd3,
        REQ_LOOKUP      = 3'd4
    } t_req_type;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK   = 2'd0,
        ST_MISS = 2'd1,
        ST_FULL = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        OP_HOLD,
        OP_INSERT,
        OP_UPDATE,
        OP_DELETE
    } t_cell_op;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EVAL,
        S_SELECT,
        S_APPLY
    } t_state;

    typedef logic [TABLE_DEPTH-1:0] t_row;

    typedef struct packed {
        logic [ID_W-1:0]   key_id;
        logic [TIME_W-1:0] now;
        logic [TIME_W-1:0] send_start;
        logic [TIME_W-1:0] send_stop;
        logic [TIME_W-1:0] accept_start;
        logic [TIME_W-1:0] accept_stop;
    } t_req;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [TIME_W-1:0] send_start;
        logic [TIME_W-1:0] send_stop;
        logic [TIME_W-1:0] accept_start;
        logic [TIME_W-1:0] accept_stop;
    } t_key;

    typedef struct packed {
        logic valid;
        t_key key;
    } t_entry;

    typedef struct packed {
        logic ge;
        logic eq;
        logic snd;
        logic acc;
    } t_flags;

    typedef struct packed {
        t_cell_op op;
        logic     here;
        logic     shift;
    } t_cell_cmd;

    // A window is open when its start is zero, or when now lies between start
    // and a stop that is either at or after now or the no-expiry marker.
    function automatic logic window_open(input logic [TIME_W-1:0] start,
                                         input logic [TIME_W-1:0] stop,
                                         input logic [TIME_W-1:0] now);
        logic after_start;
        logic before_stop;
        after_start = ($signed(start) <= $signed(now));
        before_stop = ($signed(now) <= $signed(stop)) || (stop == '1);
        return (start == '0) || (after_start && before_stop);
    endfunction

endpackage

@@ rtl/core/klt_if.sv @@
// Request and response channel interfaces of the key lifetime table.
interface klt_req_if import klt_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [REQ_W-1:0]  req_type;
    logic [ID_W-1:0]   key_id;
    logic [TIME_W-1:0] now;
    logic [TIME_W-1:0] send_start;
    logic [TIME_W-1:0] send_end;
    logic [TIME_W-1:0] accept_start;
    logic [TIME_W-1:0] accept_end;

    modport source (
        output valid, req_type, key_id, now, send_start, send_end,
               accept_start, accept_end,
        input  ready
    );
    modport sink (
        input  valid, req_type, key_id, now, send_start, send_end,
               accept_start, accept_end,
        output ready
    );
endinterface

interface klt_rsp_if import klt_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [ID_W-1:0]     found_id;
    logic [COUNT_W-1:0]  entry_count;

    modport source (
        output valid, status, found_id, entry_count,
        input  ready
    );
    modport sink (
        input  valid, status, found_id, entry_count,
        output ready
    );
endinterface

@@ rtl/core/klt_cell.sv @@
// One table slot: holds a key with its windows, compares it and shifts with its neighbors.
module klt_cell import klt_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_req      i_req,
    input  t_entry    i_below,
    input  t_entry    i_above,
    input  t_cell_cmd i_cmd,
    output t_entry    o_entry,
    output t_flags    o_flags
);

    logic   r_valid;
    logic   n_valid;
    t_key   r_key;
    t_key   n_key;
    t_flags r_flags;
    t_flags n_flags;

    always_comb begin
        n_valid = r_valid;
        n_key   = r_key;
        unique case (i_cmd.op)
            OP_HOLD: begin
            end
            OP_INSERT: begin
                if (i_cmd.here) begin
                    n_valid            = 1'b1;
                    n_key.id           = i_req.key_id;
                    n_key.send_start   = i_req.send_start;
                    n_key.send_stop    = i_req.send_stop;
                    n_key.accept_start = i_req.accept_start;
                    n_key.accept_stop  = i_req.accept_stop;
                end else if (i_cmd.shift) begin
                    n_valid = i_below.valid;
                    n_key   = i_below.key;
                end
            end
            OP_UPDATE: begin
                if (i_cmd.here) begin
                    n_key.send_start   = i_req.send_start;
                    n_key.send_stop    = i_req.send_stop;
                    n_key.accept_start = i_req.accept_start;
                    n_key.accept_stop  = i_req.accept_stop;
                end
            end
            OP_DELETE: begin
                if (i_cmd.shift) begin
                    n_valid = i_above.valid;
                    n_key   = i_above.key;
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_flags.ge  = r_valid && (r_key.id >= i_req.key_id);
        n_flags.eq  = r_valid && (r_key.id == i_req.key_id);
        n_flags.snd = r_valid && window_open(r_key.send_start, r_key.send_stop, i_req.now);
        n_flags.acc = n_flags.ge &&
                      window_open(r_key.accept_start, r_key.accept_stop, i_req.now);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key   <= n_key;
        r_flags <= n_flags;
    end

    assign o_entry.valid = r_valid;
    assign o_entry.key   = r_key;
    assign o_flags       = r_flags;

endmodule

@@ rtl/core/key_lifetime_table.sv @@
// Top level of the key lifetime table: a sorted chain of key cells with a request sequencer.
//
// Usage: requests arrive on i_req (valid/ready), one beat per request, and each
// request yields exactly one response beat on o_rsp (status, found_id,
// entry_count). Write inserts or updates a key, delete removes it, the two find
// requests return the lowest id whose send or accept window is open at now
// (find-accept only for ids at or above key_id), and lookup tests an exact id.
// Sequencing: a request passes through three steps after its accepting edge,
// up to the edge at which its response is registered: one in which every cell
// compares its own key, one to pick the first hit and plan the shift, and one
// in which the chain shifts or rewrites in place. A new request is only taken
// in the idle step that follows these three; requests are handled one at a
// time.
// Reset: i_rst_n is synchronous and active low; it empties the table and
// drops any pending response. No clearing pass is needed.
// Stalls: the response sits in an output register; a new request is taken
// while it waits. If the receiver still holds the previous response when the
// next one is ready, the sequencer waits in its last step and the table is
// not changed until the response slot frees.
module key_lifetime_table import klt_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    klt_req_if.sink   i_req,
    klt_rsp_if.source o_rsp
);

    t_state r_state;
    t_state n_state;

    t_req                r_req;
    logic [REQ_W-1:0]    r_req_type;

    t_entry    w_entry [TABLE_DEPTH];
    t_flags    w_flags [TABLE_DEPTH];
    t_cell_cmd w_cmd   [TABLE_DEPTH];

    t_row w_valid;
    t_row w_ge;
    t_row w_eq;
    t_row w_snd;
    t_row w_acc;
    t_row w_free;
    t_row w_pos;
    t_row w_snd_hit;
    t_row w_acc_hit;
    t_row w_hit;

    logic [ID_W-1:0] w_sel_id;

    t_cell_op            n_act_op;
    t_row                n_act_here;
    t_row                n_act_shift;
    t_status             n_status;
    logic [ID_W-1:0]     n_found;
    logic [CNT_W-1:0]    n_held_next;

    t_cell_op            r_act_op;
    t_row                r_act_here;
    t_row                r_act_shift;
    t_status             r_status;
    logic [ID_W-1:0]     r_found;
    logic [CNT_W-1:0]    r_held_next;
    logic [CNT_W-1:0]    r_held;

    logic                r_out_valid;
    logic [STATUS_W-1:0] r_out_status;
    logic [ID_W-1:0]     r_out_found;
    logic [COUNT_W-1:0]  r_out_count;

    logic               w_in_ready;
    logic               w_accept;
    logic               w_out_free;
    logic               w_apply;
    logic [CNT_W+4:0]   w_count_ext;

    // Request channel.
    assign w_accept = i_req.valid && w_in_ready;
    assign i_req.ready = w_in_ready;

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req_type         <= i_req.req_type;
            r_req.key_id       <= i_req.key_id;
            r_req.now          <= i_req.now;
            r_req.send_start   <= i_req.send_start;
            r_req.send_stop    <= i_req.send_end;
            r_req.accept_start <= i_req.accept_start;
            r_req.accept_stop  <= i_req.accept_end;
        end
    end

    // Chain of cells; slot 0 holds the lowest id.
    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
        t_entry w_below;
        t_entry w_above;

        if (g == 0) begin : g_first
            assign w_below = '0;
        end else begin : g_inner_lo
            assign w_below = w_entry[g-1];
        end

        if (g == TABLE_DEPTH - 1) begin : g_last
            assign w_above = '0;
        end else begin : g_inner_hi
            assign w_above = w_entry[g+1];
        end

        assign w_cmd[g].op    = w_apply ? r_act_op : OP_HOLD;
        assign w_cmd[g].here  = r_act_here[g];
        assign w_cmd[g].shift = r_act_shift[g];

        klt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_req   (r_req),
            .i_below (w_below),
            .i_above (w_above),
            .i_cmd   (w_cmd[g]),
            .o_entry (w_entry[g]),
            .o_flags (w_flags[g])
        );

        assign w_valid[g] = w_entry[g].valid;
        assign w_ge[g]    = w_flags[g].ge;
        assign w_eq[g]    = w_flags[g].eq;
        assign w_snd[g]   = w_flags[g].snd;
        assign w_acc[g]   = w_flags[g].acc;
    end

    // Entries are packed and sorted, so the cells at or above the insertion
    // point form a contiguous run; the lowest of them is the insertion slot.
    assign w_free    = w_ge | ~w_valid;
    assign w_pos     = w_free & (~w_free + 1'b1);
    assign w_snd_hit = w_snd & (~w_snd + 1'b1);
    assign w_acc_hit = w_acc & (~w_acc + 1'b1);
    assign w_hit     = (r_req_type == REQ_FIND_SEND) ? w_snd_hit : w_acc_hit;

    always_comb begin
        w_sel_id = '0;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            w_sel_id = w_sel_id | (w_entry[i].key.id & {ID_W{w_hit[i]}});
        end
    end

    always_comb begin
        n_act_op    = OP_HOLD;
        n_act_here  = w_eq;
        n_act_shift = w_free;
        n_status    = ST_MISS;
        n_found     = '0;
        n_held_next = r_held;
        unique case (t_req_type'(r_req_type))
            REQ_WRITE: begin
                if (|w_eq) begin
                    n_act_op = OP_UPDATE;
                    n_status = ST_OK;
                    n_found  = r_req.key_id;
                end else if (&w_valid) begin
                    n_status = ST_FULL;
                end else begin
                    n_act_op    = OP_INSERT;
                    n_act_here  = w_pos;
                    n_status    = ST_OK;
                    n_found     = r_req.key_id;
                    n_held_next = r_held + 1'b1;
                end
            end
            REQ_DELETE: begin
                if (|w_eq) begin
                    n_act_op    = OP_DELETE;
                    n_status    = ST_OK;
                    n_found     = r_req.key_id;
                    n_held_next = r_held - 1'b1;
                end
            end
            REQ_LOOKUP: begin
                if (|w_eq) begin
                    n_status = ST_OK;
                    n_found  = r_req.key_id;
                end
            end
            REQ_FIND_SEND, REQ_FIND_ACCEPT: begin
                if (|w_hit) begin
                    n_status = ST_OK;
                    n_found  = w_sel_id;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_SELECT) begin
            r_act_op    <= n_act_op;
            r_act_here  <= n_act_here;
            r_act_shift <= n_act_shift;
            r_status    <= n_status;
            r_found     <= n_found;
            r_held_next <= n_held_next;
        end
    end

    // Sequencer: next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (w_accept) begin
                n_state = S_EVAL;
            end
            S_EVAL:   n_state = S_SELECT;
            S_SELECT: n_state = S_APPLY;
            S_APPLY:  if (w_out_free) begin
                n_state = S_IDLE;
            end
            default:  n_state = S_IDLE;
        endcase
    end

    // Sequencer: outputs.
    always_comb begin
        w_in_ready = (r_state == S_IDLE);
        w_apply    = (r_state == S_APPLY) && w_out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_held  <= '0;
        end else begin
            r_state <= n_state;
            if (w_apply) begin
                r_held <= r_held_next;
            end
        end
    end

    // Response register.
    assign w_out_free  = !r_out_valid || o_rsp.ready;
    assign w_count_ext = {5'd0, r_held_next};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_apply) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_apply) begin
            r_out_status <= r_status;
            r_out_found  <= r_found;
            r_out_count  <= w_count_ext[COUNT_W-1:0];
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.status      = r_out_status;
    assign o_rsp.found_id    = r_out_found;
    assign o_rsp.entry_count = r_out_count;

endmodule
